FILE: hw/rtl/psq_pkg.sv
// Shared types, codes and character constants of the Polybius square codec.
`default_nettype none

package psq_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_KEY    = 2'd1,
    ST_UNBALANCED = 2'd2,
    ST_BAD_DIGIT  = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DECRYPT_MODE = 2'd0;
  localparam cfg_idx_t CFG_KEY_LOW      = 2'd1;
  localparam cfg_idx_t CFG_KEY_MID      = 2'd2;
  localparam cfg_idx_t CFG_KEY_LAST     = 2'd3;

  localparam int CFG_DATA_W  = 60;
  localparam int KEY_ENTRIES = 25;
  localparam int KEY_SIDE    = 5;
  localparam int ENTRIES_PER_WORD = 12;

  // Most results one item can cause.
  localparam int JOB_MAX  = 5;
  localparam int JOB_IDX_W = $clog2(JOB_MAX);
  localparam int JOB_CNT_W = $clog2(JOB_MAX + 1);

  // Job queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Group and line lengths.
  localparam logic [2:0] GROUP_LEN       = 3'd5;
  localparam logic [3:0] LINE_GROUPS_ENC = 4'd6;
  localparam logic [3:0] LINE_GROUPS_DEC = 4'd10;
  localparam logic [4:0] LETTER_I_IDX    = 5'd8;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_ONE    = 8'd49;
  localparam logic [7:0] CH_FIVE   = 8'd53;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_UP_A   = 8'd65;
  localparam logic [7:0] CH_UP_I   = 8'd73;
  localparam logic [7:0] CH_UP_Z   = 8'd90;
  localparam logic [7:0] CH_LO_A   = 8'd97;
  localparam logic [7:0] CH_LO_Z   = 8'd122;
  localparam logic [7:0] CASE_DIFF = 8'd32;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    status_t    status;
  } out_item_t;

  typedef struct packed {
    logic                    valid;
    cfg_idx_t                index;
    logic [CFG_DATA_W-1:0]   data;
  } cfg_write_t;

  // All results of one item; they share one status.
  typedef struct packed {
    logic [JOB_MAX-1:0][7:0] chars;
    logic [JOB_CNT_W-1:0]    count;
    status_t                 status;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/psq_front.sv
// Front part: configuration, key check, item classification and grouping state.
`default_nettype none

module psq_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire psq_pkg::cfg_write_t cfg_wr,
  input  wire logic                accept,
  input  wire psq_pkg::in_item_t   item,
  output psq_pkg::job_t            job,
  output logic                     push
);
  import psq_pkg::*;

  logic                  decrypt_r;
  logic [CFG_DATA_W-1:0] key_low_r;
  logic [CFG_DATA_W-1:0] key_mid_r;
  logic [4:0]            key_last_r;

  logic [2:0] lig_r, lig_nxt;
  logic [3:0] gil_r, gil_nxt;
  logic [2:0] prow_r, prow_nxt;
  logic       rpend_r, rpend_nxt;

  logic [4:0]            key_e [KEY_ENTRIES];
  logic [KEY_ENTRIES-1:0] seen;
  logic                  key_bad;
  logic                  key_ok;

  logic [7:0] up_c;
  logic [4:0] letter_idx;
  logic [2:0] enc_row;
  logic [2:0] enc_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_r  <= 1'b0;
      key_low_r  <= '0;
      key_mid_r  <= '0;
      key_last_r <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_DECRYPT_MODE: decrypt_r  <= cfg_wr.data[0];
        CFG_KEY_LOW:      key_low_r  <= cfg_wr.data;
        CFG_KEY_MID:      key_mid_r  <= cfg_wr.data;
        CFG_KEY_LAST:     key_last_r <= cfg_wr.data[4:0];
        default: ;
      endcase
    end
  end

  // Unpack the square and check that it is a permutation of 0..24.
  always_comb begin
    seen    = '0;
    key_bad = 1'b0;
    for (int p = 0; p < ENTRIES_PER_WORD; p++) begin
      key_e[p]                    = key_low_r[5*p +: 5];
      key_e[p + ENTRIES_PER_WORD] = key_mid_r[5*p +: 5];
    end
    key_e[KEY_ENTRIES-1] = key_last_r;
    for (int p = 0; p < KEY_ENTRIES; p++) begin
      if (key_e[p] > 5'(KEY_ENTRIES - 1)) begin
        key_bad = 1'b1;
      end else begin
        seen[key_e[p]] = 1'b1;
      end
    end
    key_ok = !key_bad && (&seen);
  end

  // Letter index with J folded into I, and its place in the square.
  always_comb begin
    up_c = item.in_byte;
    if (up_c >= CH_LO_A && up_c <= CH_LO_Z) begin
      up_c = up_c - CASE_DIFF;
    end
    if (up_c > CH_UP_I) begin
      letter_idx = 5'(up_c - CH_UP_A - 8'd1);
    end else begin
      letter_idx = 5'(up_c - CH_UP_A);
    end
    enc_row = '0;
    enc_col = '0;
    for (int r = 0; r < KEY_SIDE; r++) begin
      for (int c = 0; c < KEY_SIDE; c++) begin
        if (key_e[r*KEY_SIDE + c] == letter_idx) begin
          enc_row = 3'(r);
          enc_col = 3'(c);
        end
      end
    end
  end

  always_comb begin
    logic                 letter_done;
    logic [JOB_CNT_W-1:0] n;
    logic [2:0]           col;
    logic [4:0]           pos;
    logic [4:0]           x;
    logic [3:0]           limit;

    lig_nxt     = lig_r;
    gil_nxt     = gil_r;
    prow_nxt    = prow_r;
    rpend_nxt   = rpend_r;
    job         = '0;
    job.status  = ST_OK;
    n           = '0;
    letter_done = 1'b0;
    col         = 3'(item.in_byte - CH_ONE);
    pos         = 5'(prow_r) * 5'd5 + 5'(col);
    x           = key_e[pos];
    limit       = decrypt_r ? LINE_GROUPS_DEC : LINE_GROUPS_ENC;

    if (item.end_of_text) begin
      job.chars[0] = CH_CR;
      job.chars[1] = CH_LF;
      n            = JOB_CNT_W'(2);
      job.status   = rpend_r ? ST_UNBALANCED : ST_OK;
      lig_nxt      = '0;
      gil_nxt      = '0;
      prow_nxt     = '0;
      rpend_nxt    = 1'b0;
    end else if (!key_ok) begin
      job.chars[0] = CH_NUL;
      n            = JOB_CNT_W'(1);
      job.status   = ST_BAD_KEY;
    end else if (!decrypt_r) begin
      if (up_c >= CH_UP_A && up_c <= CH_UP_Z) begin
        job.chars[0] = CH_ONE + 8'(enc_row);
        job.chars[1] = CH_ONE + 8'(enc_col);
        n            = JOB_CNT_W'(2);
        letter_done  = 1'b1;
      end
    end else if (item.in_byte >= CH_ZERO && item.in_byte <= CH_NINE) begin
      if (item.in_byte < CH_ONE || item.in_byte > CH_FIVE) begin
        job.chars[0] = CH_NUL;
        n            = JOB_CNT_W'(1);
        job.status   = ST_BAD_DIGIT;
      end else if (!rpend_r) begin
        prow_nxt  = col;
        rpend_nxt = 1'b1;
      end else begin
        if (x > LETTER_I_IDX) begin
          x = x + 5'd1;
        end
        job.chars[0] = CH_UP_A + 8'(x);
        n            = JOB_CNT_W'(1);
        prow_nxt     = '0;
        rpend_nxt    = 1'b0;
        letter_done  = 1'b1;
      end
    end

    if (letter_done) begin
      lig_nxt = lig_r + 3'd1;
      if (lig_nxt >= GROUP_LEN) begin
        job.chars[n[JOB_IDX_W-1:0]] = CH_SPACE;
        n       = n + JOB_CNT_W'(1);
        lig_nxt = '0;
        gil_nxt = gil_r + 4'd1;
        if (gil_nxt >= limit) begin
          job.chars[n[JOB_IDX_W-1:0]] = CH_CR;
          n = n + JOB_CNT_W'(1);
          job.chars[n[JOB_IDX_W-1:0]] = CH_LF;
          n = n + JOB_CNT_W'(1);
          gil_nxt = '0;
        end
      end
    end

    job.count = n;
    push      = accept && (n != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lig_r   <= '0;
      gil_r   <= '0;
      prow_r  <= '0;
      rpend_r <= 1'b0;
    end else if (accept) begin
      lig_r   <= lig_nxt;
      gil_r   <= gil_nxt;
      prow_r  <= prow_nxt;
      rpend_r <= rpend_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/psq_queue.sv
// Short job queue that decouples the front part from the back part.
`default_nettype none

module psq_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire psq_pkg::job_t  push_job,
  input  wire logic           pop,
  output psq_pkg::job_t       head,
  output psq_pkg::q_status_t  stat
);
  import psq_pkg::*;

  job_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  assign head       = q_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: hw/rtl/psq_back.sv
// Back part: walks the head job, one result per cycle unless stalled.
`default_nettype none

module psq_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire psq_pkg::job_t      head,
  input  wire logic               q_empty,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output psq_pkg::out_item_t      out_data
);
  import psq_pkg::*;

  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;
  logic [JOB_CNT_W-1:0] idx_r, idx_nxt;
  logic                 load;
  logic                 is_last;

  assign load    = !out_valid_r || !out_stall;
  assign is_last = (idx_r == head.count - JOB_CNT_W'(1));

  always_comb begin
    pop           = 1'b0;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (load && !q_empty) begin
      out_data_nxt.out_char = head.chars[idx_r[JOB_IDX_W-1:0]];
      out_data_nxt.last     = is_last;
      out_data_nxt.status   = head.status;
      out_valid_nxt         = 1'b1;
      if (is_last) begin
        pop     = 1'b1;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + JOB_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/polybius_square_codec.sv
// Top level of the keyed 5x5 Polybius square codec.
//
//   Channel  Direction  Handshake             Payload
//   in_      into       in_valid / in_stall   in_data   (in_byte, end_of_text)
//   out_     out of     out_valid / out_stall out_data  (out_char, last, status)
//   cfg_     into       cfg_valid / cfg_ready cfg_index, cfg_data (60 bits)
//
// The front part takes one item per cycle while the two-entry job queue has
// room; all results of an item are formed in that same cycle.
// The back part sends one result per cycle from its output register while
// out_stall is low; it sends all results of one job before the next job.
// Reset (rst_n low at a clock edge) clears mode, key, counters and the queue.
// in_stall is high only while the queue is full; out_stall freezes the
// output register while the front keeps filling the queue.
`default_nettype none

module polybius_square_codec (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire psq_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output psq_pkg::out_item_t               out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire psq_pkg::cfg_idx_t           cfg_index,
  input  wire logic [psq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import psq_pkg::*;

  cfg_write_t cfg_wr;
  logic       in_accept;
  job_t       push_job;
  logic       push;
  job_t       head;
  q_status_t  q_stat;
  logic       pop;

  // Configuration writes are always taken at once.
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // An item enters whenever the queue can hold its results.
  assign in_stall  = q_stat.full;
  assign in_accept = in_valid && !q_stat.full;

  psq_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .accept (in_accept),
    .item   (in_data),
    .job    (push_job),
    .push   (push)
  );

  psq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  psq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // An end of text always leaves a job behind in the queue.
  a_eot_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.end_of_text |=> !q_stat.empty)
    else $error("end of text item left no job in the queue");

  // Error results stand alone and carry no character.
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_BAD_KEY || out_data.status == ST_BAD_DIGIT)
    |-> out_data.last && (out_data.out_char == CH_NUL))
    else $error("error result is not a lone null result");

  // A result only appears when a job was waiting.
  a_out_from_job: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!q_stat.empty))
    else $error("result sent without a queued job");

  // The back never pops a job that is not there.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire
